>>> hw/rtl/totp_pkg.sv
// totp_pkg: shared types and constants of the one-time password code generator
// no dependencies
`default_nettype none
package totp_pkg;
   localparam int KEY_WORDS = 8;
   localparam int KEY_BYTES_MAX = 64;
   localparam logic [7:0] IPAD = 8'h36;
   localparam logic [7:0] OPAD = 8'h5C;
   localparam logic [9:0] INNER_LEN = 10'd576;
   localparam logic [9:0] OUTER_LEN = 10'd672;
   localparam logic [3:0] DIGITS_MAX = 4'd9;

   localparam logic [1:0] CFG_KEY_LENGTH = 2'd0;
   localparam logic [1:0] CFG_DIGIT_COUNT = 2'd1;
   localparam logic [1:0] CFG_STEP_SECONDS = 2'd2;
   localparam logic [1:0] CFG_USE_COUNTER = 2'd3;

   localparam logic KIND_KEY = 1'b0;
   localparam logic KIND_GEN = 1'b1;

   typedef enum logic [1:0] {
      BLK_KEY_IPAD, BLK_COUNTER, BLK_KEY_OPAD, BLK_DIGEST
   } blk_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_LOAD, ST_ROUND, ST_FOLD, ST_TRUNC, ST_MOD, ST_OUT
   } state_type;

   typedef struct packed {
      logic        div_start;
      logic        div_skip;
      logic        load;
      blk_sel_type blk;
      logic        chain_init;
      logic        round;
      logic        fold;
      logic        save_inner;
      logic        trunc;
      logic        mod_step;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic round_last;
      logic mod_done;
   } sts_type;

   function automatic logic [29:0] pow10(input logic [3:0] d);
      logic [29:0] r;
      r = 30'd1;
      case (d)
         4'd0: r = 30'd1;
         4'd1: r = 30'd10;
         4'd2: r = 30'd100;
         4'd3: r = 30'd1000;
         4'd4: r = 30'd10000;
         4'd5: r = 30'd100000;
         4'd6: r = 30'd1000000;
         4'd7: r = 30'd10000000;
         4'd8: r = 30'd100000000;
         default: r = 30'd1000000000;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] round_k(input logic [6:0] t);
      logic [31:0] k;
      if (t < 7'd20) k = 32'h5A827999;
      else if (t < 7'd40) k = 32'h6ED9EBA1;
      else if (t < 7'd60) k = 32'h8F1BBCDC;
      else k = 32'hCA62C1D6;
      return k;
   endfunction
endpackage
`default_nettype wire

>>> hw/rtl/totp_ctrl.sv
// totp_ctrl: sequencer for division, four sha-1 compressions, truncation and modulo
// depends on totp_pkg
`default_nettype none
module totp_ctrl
   import totp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    gen_start,
   input  wire logic    use_counter,
   input  wire sts_type sts,
   input  wire logic    rsp_taken,
   output cmd_type      cmd,
   output logic         busy,
   output logic         rsp_valid
);
   state_type state_ff, state_in;
   blk_sel_type blk_ff, blk_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         blk_ff   <= BLK_KEY_IPAD;
      end else begin
         state_ff <= state_in;
         blk_ff   <= blk_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      blk_in    = blk_ff;
      cmd       = '0;
      cmd.blk   = blk_ff;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (gen_start) begin
               cmd.div_start = 1'b1;
               cmd.div_skip = use_counter;
               blk_in = BLK_KEY_IPAD;
               state_in = use_counter ? ST_LOAD : ST_DIV;
            end
         end
         ST_DIV: if (sts.div_done) state_in = ST_LOAD;
         ST_LOAD: begin
            cmd.load = 1'b1;
            cmd.chain_init = (blk_ff == BLK_KEY_IPAD) || (blk_ff == BLK_KEY_OPAD);
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (sts.round_last) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            cmd.save_inner = (blk_ff == BLK_COUNTER);
            blk_in = blk_sel_type'(blk_ff + 2'd1);
            state_in = (blk_ff == BLK_DIGEST) ? ST_TRUNC : ST_LOAD;
         end
         ST_TRUNC: begin
            cmd.trunc = 1'b1;
            state_in = ST_MOD;
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_taken) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

>>> hw/rtl/totp_dp.sv
// totp_dp: key store, restoring divider, sha-1 round datapath, truncation and modulo
// depends on totp_pkg
`default_nettype none
module totp_dp
   import totp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        key_we,
   input  wire logic [2:0]  key_slot,
   input  wire logic [63:0] key_word,
   input  wire logic [63:0] value,
   input  wire logic [6:0]  key_length,
   input  wire logic [3:0]  digit_count,
   input  wire logic [31:0] step_len,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   output logic [29:0]      code
);
   localparam int KB = KEY_WORDS * 8;

   logic [63:0] key_ff [KEY_WORDS];
   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [6:0]  dcnt_ff, dcnt_in;
   logic [159:0] chain_ff, chain_in, vars_ff, vars_in, inner_ff;
   logic [31:0] win_ff [16];
   logic [6:0]  t_ff;
   logic [30:0] bin_ff;
   logic [4:0]  mcnt_ff;
   logic [511:0] blk;
   logic [6:0]  len;
   logic [3:0]  dig;

   assign len = (key_length > 7'(KB)) ? 7'(KB) : key_length;
   assign dig = (digit_count > DIGITS_MAX) ? DIGITS_MAX : digit_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) key_ff[i] <= '0;
      end else if (key_we && ({1'b0, key_slot} < 4'(KEY_WORDS))) begin
         key_ff[key_slot] <= key_word;
      end
   end

   // restoring division, one quotient bit a cycle
   logic [32:0] trial;
   logic [31:0] divisor;
   assign divisor = (step_len == 32'd0) ? 32'd1 : step_len;
   assign trial = {rem_ff, quo_ff[63]} - {1'b0, divisor};
   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dcnt_in = dcnt_ff;
      if (cmd.div_start) begin
         quo_in = value; rem_in = '0; dcnt_in = cmd.div_skip ? 7'd64 : 7'd0;
      end else if (dcnt_ff != 7'd64) begin
         dcnt_in = dcnt_ff + 7'd1;
         if (!trial[32]) begin
            rem_in = trial[31:0]; quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[63]}; quo_in = {quo_ff[62:0], 1'b0};
         end
      end
   end
   assign sts.div_done = (dcnt_ff == 7'd63);

   always_comb begin
      blk = '0;
      case (cmd.blk)
         BLK_KEY_IPAD, BLK_KEY_OPAD: begin
            for (int i = 0; i < KEY_BYTES_MAX; i++) begin
               logic [7:0] kb;
               kb = 8'h00;
               if (i < KB && 7'(i) < len) kb = key_ff[i / 8][63 - 8 * (i % 8) -: 8];
               blk[511 - 8 * i -: 8] = kb ^ ((cmd.blk == BLK_KEY_IPAD) ? IPAD : OPAD);
            end
         end
         BLK_COUNTER: begin
            blk[511 -: 64] = quo_ff;
            blk[447 -: 8] = 8'h80;
            blk[9:0] = INNER_LEN;
         end
         default: begin
            blk[511 -: 160] = inner_ff;
            blk[351 -: 8] = 8'h80;
            blk[9:0] = OUTER_LEN;
         end
      endcase
   end

   logic [31:0] a, b, c, d, e, w, f, tmp, wnew;
   assign {a, b, c, d, e} = vars_ff;
   assign wnew = {win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0]};
   assign w = (t_ff < 7'd16) ? win_ff[0] : {wnew[30:0], wnew[31]};
   always_comb begin
      if (t_ff < 7'd20) f = (b & c) | (~b & d);
      else if (t_ff < 7'd40 || t_ff >= 7'd60) f = b ^ c ^ d;
      else f = (b & c) | (b & d) | (c & d);
   end
   assign tmp = {a[26:0], a[31:27]} + f + e + round_k(t_ff) + w;
   assign sts.round_last = (t_ff == 7'd79);

   always_comb begin
      chain_in = chain_ff;
      vars_in = vars_ff;
      if (cmd.load) begin
         if (cmd.chain_init) chain_in = 160'h67452301EFCDAB8998BADCFE10325476C3D2E1F0;
         vars_in = chain_in;
      end else if (cmd.round) begin
         vars_in = {tmp, a, {b[1:0], b[31:2]}, c, d};
      end else if (cmd.fold) begin
         for (int i = 0; i < 5; i++)
            chain_in[32 * i +: 32] = chain_ff[32 * i +: 32] + vars_ff[32 * i +: 32];
      end
   end

   // modulo by repeated subtraction of shifted modulus, 31 steps
   logic [29:0] m;
   logic [60:0] shm;
   assign m = pow10(dig);
   assign shm = {31'd0, m} << (5'd30 - mcnt_ff);
   assign sts.mod_done = (mcnt_ff == 5'd30);

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; chain_ff <= chain_in; vars_ff <= vars_in;
      if (reset) dcnt_ff <= 7'd64;
      else dcnt_ff <= dcnt_in;
      if (cmd.load) begin
         t_ff <= 7'd0;
         for (int i = 0; i < 16; i++) win_ff[i] <= blk[511 - 32 * i -: 32];
      end else if (cmd.round) begin
         t_ff <= t_ff + 7'd1;
         for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i + 1];
         win_ff[15] <= w;
      end
      if (cmd.save_inner) inner_ff <= chain_in;
      if (cmd.trunc) begin
         bin_ff <= 31'(chain_ff >> (8'd8 * (8'd16 - {4'd0, chain_ff[3:0]})));
         mcnt_ff <= 5'd0;
      end else if (cmd.mod_step && !sts.mod_done) begin
         mcnt_ff <= mcnt_ff + 5'd1;
      end
      if (cmd.mod_step) begin
         if ({30'd0, bin_ff} >= shm) bin_ff <= 31'({30'd0, bin_ff} - shm);
      end
   end
   assign code = bin_ff[29:0];
endmodule
`default_nettype wire

>>> hw/rtl/hotp_totp_code_generator_unit.sv
// One code word takes a division of the time value by the step length (none in counter
// mode), four sha-1 compressions on one shared round unit, a truncation and a modulo
// before rsp_tvalid rises. One word at a time: req_tready stays low until the code word
// has been taken.
`default_nettype none
module hotp_totp_code_generator_unit
   import totp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [135:0] req_tdata, // key_slot, key_word, time_or_count
   input  wire logic         req_tuser, // kind
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata, // code
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);
   logic [6:0] klen_ff; logic [3:0] dig_ff; logic [31:0] step_ff; logic usec_ff;
   logic [63:0] val_ff;
   cmd_type cmd; sts_type sts; logic busy; logic acc;
   logic [29:0] code;

   assign req_tready = !busy;
   assign acc = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff <= 7'd20; dig_ff <= 4'd6; step_ff <= 32'd30; usec_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CFG_KEY_LENGTH:   klen_ff <= csr_wdata[6:0];
            CFG_DIGIT_COUNT:  dig_ff <= csr_wdata[3:0];
            CFG_STEP_SECONDS: step_ff <= csr_wdata;
            CFG_USE_COUNTER:  usec_ff <= csr_wdata[0];
            default: ;
         endcase
      end
      if (acc) val_ff <= req_tdata[130:67];
   end

   totp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .gen_start(acc && req_tuser == KIND_GEN),
      .use_counter(usec_ff), .sts(sts), .rsp_taken(rsp_tready), .cmd(cmd),
      .busy(busy), .rsp_valid(rsp_tvalid)
   );

   totp_dp u_dp (
      .clock(clock), .reset(reset), .key_we(acc && req_tuser == KIND_KEY),
      .key_slot(req_tdata[2:0]), .key_word(req_tdata[66:3]),
      .value(usec_ff ? req_tdata[130:67] : (acc ? req_tdata[130:67] : val_ff)),
      .key_length(klen_ff), .digit_count(dig_ff), .step_len(step_ff),
      .cmd(cmd), .sts(sts), .code(code)
   );

   assign rsp_tdata = {2'b00, code};
endmodule
`default_nettype wire

>>> hw/rtl/totp_checker.sv
// totp_checker: port-level checks of the code generator
// depends on hotp_totp_code_generator_unit
`default_nettype none
module totp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("rsp hold");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata < 32'd1000000000) else $error("code range");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("busy while result waits");
endmodule
bind hotp_totp_code_generator_unit totp_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire
